// ----- hdl/nearest_neighbor_scale_place_top_assert.svh -----
// assertion macros for the nearest neighbor scaler checker
// expects clk and rst in scope where a macro is used
`ifndef NEAREST_NEIGHBOR_SCALE_PLACE_TOP_ASSERT_SVH
`define NEAREST_NEIGHBOR_SCALE_PLACE_TOP_ASSERT_SVH

// same-cycle implication, off during reset
`define NNSP_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("nnsp check failed");

// next-cycle implication, also live during reset
`define NNSP_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("nnsp check failed");

`endif

// ----- hdl/nnsp_pkg.sv -----
// shared types and constants of the nearest neighbor scaler
// no dependencies
`default_nettype none

package nnsp_pkg;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_FETCH = 1'b1
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [19:0] source_index;
    logic [7:0]  pixel_in;
    logic [11:0] screen_x;
    logic [11:0] screen_y;
  } in_item_t;

  typedef struct packed {
    logic [7:0] pixel_out;
    logic       from_image;
  } out_item_t;

  localparam int CFG_IW = 3;
  localparam int CFG_DW = 14;

  localparam logic [CFG_IW-1:0] REG_SCREEN_WIDTH  = 3'd0;
  localparam logic [CFG_IW-1:0] REG_SCREEN_HEIGHT = 3'd1;
  localparam logic [CFG_IW-1:0] REG_DEST_WIDTH    = 3'd2;
  localparam logic [CFG_IW-1:0] REG_DEST_HEIGHT   = 3'd3;
  localparam logic [CFG_IW-1:0] REG_OFFSET_X      = 3'd4;
  localparam logic [CFG_IW-1:0] REG_OFFSET_Y      = 3'd5;
  localparam logic [CFG_IW-1:0] REG_SOURCE_WIDTH  = 3'd6;
  localparam logic [CFG_IW-1:0] REG_SOURCE_HEIGHT = 3'd7;

  // span divider: 25-bit dividend, 12 quotient bits, one per stage
  localparam int NUM_W    = 25;
  localparam int DIV_BITS = 12;

  // accept edge to the edge that takes the result
  localparam int LATENCY = 18;

endpackage

`default_nettype wire

// ----- hdl/nearest_neighbor_scale_place_top.sv -----
// nearest neighbor scaler: clip, span division pipeline, pixel store
// depends on nnsp_pkg and nnsp_ram
`default_nettype none

// done is registered, after a fetch runs the clip, divider and store stages
// throughput: one beat per cycle out of reset, loads and fetches mixed
//   freely; the span divider is 12 restoring stages, a quotient bit each
// reset: synchronous, clears the pipeline valids and reloads the registers;
//   busy is high only during reset; the pixel store is not cleared
// the result strobe cannot be held off, so the pipeline never stalls
module nearest_neighbor_scale_place_top #(
  parameter int MAX_SOURCE_PIXELS = 1048576
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  nnsp_pkg::in_item_t              item,
  output logic                            done,
  output nnsp_pkg::out_item_t             result,
  input  logic                            cfg_we,
  input  logic [nnsp_pkg::CFG_IW-1:0]     cfg_index,
  input  logic [nnsp_pkg::CFG_DW-1:0]     cfg_data
);

  import nnsp_pkg::*;

  localparam int AW    = $clog2(MAX_SOURCE_PIXELS);
  localparam int IDX_W = (AW > 20) ? AW : 20;
  localparam int LIN_W = (AW > 24) ? AW : 24;

  typedef struct packed {
    op_t         op;
    logic        draw;
    logic [19:0] src_index;
    logic [7:0]  pix;
  } ctl_t;

  // configuration registers
  logic        [12:0] screen_width;
  logic        [12:0] screen_height;
  logic        [13:0] dest_width;
  logic        [13:0] dest_height;
  logic signed [12:0] offset_x;
  logic signed [12:0] offset_y;
  logic        [11:0] source_width;
  logic        [11:0] source_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= 13'd640;
      screen_height <= 13'd480;
      dest_width    <= 14'd640;
      dest_height   <= 14'd480;
      offset_x      <= 13'sd0;
      offset_y      <= 13'sd0;
      source_width  <= 12'd640;
      source_height <= 12'd480;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SCREEN_WIDTH:  screen_width  <= cfg_data[12:0];
        REG_SCREEN_HEIGHT: screen_height <= cfg_data[12:0];
        REG_DEST_WIDTH:    dest_width    <= cfg_data[13:0];
        REG_DEST_HEIGHT:   dest_height   <= cfg_data[13:0];
        REG_OFFSET_X:      offset_x      <= $signed(cfg_data[12:0]);
        REG_OFFSET_Y:      offset_y      <= $signed(cfg_data[12:0]);
        REG_SOURCE_WIDTH:  source_width  <= cfg_data[11:0];
        REG_SOURCE_HEIGHT: source_height <= cfg_data[11:0];
      endcase
    end
  end

  logic accept;

  assign busy   = rst;
  assign accept = start && !busy;

  // stage 0: input register
  logic     v0;
  in_item_t in0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else begin
      v0 <= accept;
    end
    in0 <= item;
  end

  // stage 1: clipping and offset
  logic signed [13:0] dx;
  logic signed [13:0] dy;
  logic               on_screen;
  logic               sizes_ok;
  logic               in_rect;
  ctl_t               c0;

  always_comb begin
    dx        = $signed({2'b00, in0.screen_x}) - $signed({offset_x[12], offset_x});
    dy        = $signed({2'b00, in0.screen_y}) - $signed({offset_y[12], offset_y});
    on_screen = ({1'b0, in0.screen_x} < screen_width) &&
                ({1'b0, in0.screen_y} < screen_height);
    sizes_ok  = (dest_width != 14'd0) && (dest_height != 14'd0) &&
                (source_width != 12'd0) && (source_height != 12'd0);
    in_rect   = !dx[13] && !dy[13] &&
                ({1'b0, dx[12:0]} < dest_width) &&
                ({1'b0, dy[12:0]} < dest_height);
    c0.op        = in0.op;
    c0.draw      = (in0.op == OP_FETCH) && on_screen && sizes_ok && in_rect;
    c0.src_index = in0.source_index;
    c0.pix       = in0.pixel_in;
  end

  logic        v1;
  ctl_t        c1;
  logic [12:0] dx1;
  logic [12:0] dy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= v0;
    end
    c1  <= c0;
    dx1 <= dx[12:0];
    dy1 <= dy[12:0];
  end

  // stage 2: span numerators (d+1)*src-1
  logic [13:0] dxp;
  logic [13:0] dyp;
  logic [25:0] prod_x;
  logic [25:0] prod_y;

  always_comb begin
    dxp    = {1'b0, dx1} + 14'd1;
    dyp    = {1'b0, dy1} + 14'd1;
    prod_x = 26'(dxp) * 26'(source_width);
    prod_y = 26'(dyp) * 26'(source_height);
  end

  // divider pipeline, entry 0 is the numerator register
  logic                dv [DIV_BITS+1];
  ctl_t                dc [DIV_BITS+1];
  logic [NUM_W-1:0]    xr [DIV_BITS+1];
  logic [NUM_W-1:0]    yr [DIV_BITS+1];
  logic [DIV_BITS-1:0] xq [DIV_BITS+1];
  logic [DIV_BITS-1:0] yq [DIV_BITS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else begin
      dv[0] <= v1;
    end
    dc[0] <= c1;
    xr[0] <= NUM_W'(prod_x - 26'd1);
    yr[0] <= NUM_W'(prod_y - 26'd1);
    xq[0] <= '0;
    yq[0] <= '0;
  end

  for (genvar k = 0; k < DIV_BITS; k++) begin : g_div
    localparam int SH = DIV_BITS - 1 - k;
    logic [NUM_W-1:0] xd;
    logic [NUM_W-1:0] yd;
    logic             xge;
    logic             yge;

    always_comb begin
      xd  = NUM_W'(dest_width) << SH;
      yd  = NUM_W'(dest_height) << SH;
      xge = xr[k] >= xd;
      yge = yr[k] >= yd;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[k+1] <= 1'b0;
      end else begin
        dv[k+1] <= dv[k];
      end
      dc[k+1] <= dc[k];
      xr[k+1] <= xge ? (xr[k] - xd) : xr[k];
      yr[k+1] <= yge ? (yr[k] - yd) : yr[k];
      // quotient bit SH is still clear here, so or it in
      xq[k+1] <= xq[k] | (DIV_BITS'(xge) << SH);
      yq[k+1] <= yq[k] | (DIV_BITS'(yge) << SH);
    end
  end

  // stage 15: store address, row*width+col for fetch, index for load
  logic [LIN_W-1:0] lin;
  logic [IDX_W-1:0] idx_ext;
  ctl_t             cl;
  logic             v15;
  ctl_t             c15;
  logic [AW-1:0]    addr15;

  always_comb begin
    cl      = dc[DIV_BITS];
    lin     = LIN_W'(yq[DIV_BITS]) * LIN_W'(source_width) + LIN_W'(xq[DIV_BITS]);
    idx_ext = IDX_W'(cl.src_index);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v15 <= 1'b0;
    end else begin
      v15 <= dv[DIV_BITS];
    end
    c15    <= cl;
    addr15 <= (cl.op == OP_LOAD) ? idx_ext[AW-1:0] : lin[AW-1:0];
  end

  // stage 16: store access, loads write where fetches read so order holds
  logic [7:0] rdata;
  logic       v16;
  ctl_t       c16;

  nnsp_ram #(
    .WIDTH(8),
    .DEPTH(MAX_SOURCE_PIXELS)
  ) u_store (
    .clk  (clk),
    .we   (v15 && (c15.op == OP_LOAD)),
    .addr (addr15),
    .wdata(c15.pix),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v16 <= 1'b0;
    end else begin
      v16 <= v15;
    end
    c16 <= c15;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v16 && (c16.op == OP_FETCH);
    end
    result.pixel_out  <= c16.draw ? rdata : 8'd0;
    result.from_image <= c16.draw;
  end

endmodule

`default_nettype wire

// ----- hdl/nnsp_ram.sv -----
// generic single-port ram with registered read
// no dependencies
`default_nettype none

module nnsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

// ----- hdl/nnsp_checker.sv -----
// port-level checker for the nearest neighbor scaler, bound to the top level
// depends on nnsp_pkg and nearest_neighbor_scale_place_top_assert.svh
`default_nettype none
`include "nearest_neighbor_scale_place_top_assert.svh"

module nnsp_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        start,
  input logic                        busy,
  input nnsp_pkg::in_item_t          item,
  input logic                        done,
  input nnsp_pkg::out_item_t         result,
  input logic                        cfg_we,
  input logic [nnsp_pkg::CFG_IW-1:0] cfg_index,
  input logic [nnsp_pkg::CFG_DW-1:0] cfg_data
);

  import nnsp_pkg::*;

  logic [4:0]  age;
  logic        settled;
  logic [12:0] sw;
  logic [12:0] sh;
  logic        acc_fetch;
  logic        acc_off;

  // cycles since reset, saturating at the pipeline latency, and screen size copies
  always_ff @(posedge clk) begin
    if (rst) begin
      age <= '0;
      sw  <= 13'd640;
      sh  <= 13'd480;
    end else begin
      if (age != 5'(LATENCY)) begin
        age <= age + 5'd1;
      end
      if (cfg_we && (cfg_index == REG_SCREEN_WIDTH)) begin
        sw <= cfg_data[12:0];
      end
      if (cfg_we && (cfg_index == REG_SCREEN_HEIGHT)) begin
        sh <= cfg_data[12:0];
      end
    end
  end

  always_comb begin
    settled   = (age == 5'(LATENCY));
    acc_fetch = start && !busy && (item.op == OP_FETCH);
    acc_off   = acc_fetch &&
                (({1'b0, item.screen_x} >= sw) || ({1'b0, item.screen_y} >= sh));
  end

  // every fetch beat and nothing else comes back after the fixed latency
  `NNSP_ASSERT_IMP(a_done_latency, settled, done == $past(acc_fetch, LATENCY))
  // off-screen fetches always come back as background
  `NNSP_ASSERT_IMP(a_off_screen, settled && $past(acc_off, LATENCY), done && !result.from_image)
  `NNSP_ASSERT_IMP(a_bg_zero, done && !result.from_image, result.pixel_out == 8'd0)
  `NNSP_ASSERT_NXT(a_rst_quiet, rst, !done)

endmodule

bind nearest_neighbor_scale_place_top nnsp_checker u_nnsp_checker (.*);

`default_nettype wire
